// File: rtl/lazy_segment_tree_range_add_sum_core_defines.svh
// assertion macros for the lazy segment tree core
`ifndef LAZY_SEGMENT_TREE_RANGE_ADD_SUM_CORE_DEFINES_SVH
`define LAZY_SEGMENT_TREE_RANGE_ADD_SUM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LST_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lst assertion failed");
`define LST_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("lst assertion failed");
`else
`define LST_ASSERT(label, prop)
`define LST_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/lst_pkg.sv
// shared types and constants for the lazy segment tree core
`default_nettype none
package lst_pkg;
   localparam int LEAVES      = 1024;
   localparam int NODE_COUNT  = 4 * LEAVES;
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int POS_W       = 11;
   localparam int LEN_W       = 11;
   localparam int DATA_W      = 64;
   localparam int STACK_DEPTH = 16;
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(LEAVES);

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_START,
      DP_READ,
      DP_MUL_LO,
      DP_MUL_HI,
      DP_WR_SUM,
      DP_RD_CHILD,
      DP_WR_CHILD,
      DP_CLR_PEND,
      DP_LOAD_V,
      DP_ACC,
      DP_RD_SUM_A,
      DP_RD_SUM_B,
      DP_WR_PARENT,
      DP_OUT_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [NODE_W-1:0] addr;
      logic [LEN_W-1:0]  len;
   } dp_cmd_type;

   typedef struct packed {
      logic p_zero;
   } dp_status_type;
endpackage
`default_nettype wire

// File: rtl/lst_datapath.sv
// node memories, multiply and accumulate datapath of the lazy segment tree
`default_nettype none
module lst_datapath (
   input  wire logic                       clock,
   input  wire lst_pkg::dp_cmd_type        cmd,
   output lst_pkg::dp_status_type          status,
   input  wire logic [lst_pkg::DATA_W-1:0] req_add_value,
   output logic [lst_pkg::DATA_W-1:0]      rsp_range_sum
);
   import lst_pkg::*;

   logic [DATA_W-1:0] sum_mem  [NODE_COUNT];
   logic [DATA_W-1:0] pend_mem [NODE_COUNT];

   logic [DATA_W-1:0] s_ff, p_ff, c_ff, t_ff, prod_ff, v_ff, acc_ff, out_ff;
   logic [42:0]       prod_lo;
   logic [31:0]       prod_hi;
   logic [DATA_W-1:0] s_new;

   assign prod_lo = {11'b0, p_ff[31:0]} * {32'b0, cmd.len};
   assign prod_hi = p_ff[63:32] * {21'b0, cmd.len};
   assign s_new   = s_ff + prod_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_CLEAR: begin
            sum_mem[cmd.addr]  <= '0;
            pend_mem[cmd.addr] <= '0;
         end
         DP_START: begin
            v_ff   <= req_add_value;
            acc_ff <= '0;
         end
         DP_READ: begin
            s_ff <= sum_mem[cmd.addr];
            p_ff <= pend_mem[cmd.addr];
         end
         DP_MUL_LO: prod_ff <= {21'b0, prod_lo};
         DP_MUL_HI: prod_ff <= prod_ff + {prod_hi, 32'b0};
         DP_WR_SUM: begin
            sum_mem[cmd.addr] <= s_new;
            s_ff              <= s_new;
         end
         DP_RD_CHILD:  c_ff <= pend_mem[cmd.addr];
         DP_WR_CHILD:  pend_mem[cmd.addr] <= c_ff + p_ff;
         DP_CLR_PEND:  pend_mem[cmd.addr] <= '0;
         DP_LOAD_V:    p_ff <= v_ff;
         DP_ACC:       acc_ff <= acc_ff + s_ff;
         DP_RD_SUM_A:  s_ff <= sum_mem[cmd.addr];
         DP_RD_SUM_B:  t_ff <= sum_mem[cmd.addr];
         DP_WR_PARENT: sum_mem[cmd.addr] <= s_ff + t_ff;
         DP_OUT_LOAD:  out_ff <= acc_ff;
         default: ;
      endcase
   end

   assign status.p_zero = (p_ff == '0);
   assign rsp_range_sum = out_ff;
endmodule
`default_nettype wire

// File: rtl/lst_ctrl.sv
// traversal controller of the lazy segment tree
`default_nettype none
`include "lazy_segment_tree_range_add_sum_core_defines.svh"
module lst_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_func,
   input  wire logic [lst_pkg::POS_W-1:0] req_range_low,
   input  wire logic [lst_pkg::POS_W-1:0] req_range_high,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic                      csr_we,
   input  wire logic [lst_pkg::POS_W-1:0] csr_wdata,
   output lst_pkg::dp_cmd_type            cmd,
   input  wire lst_pkg::dp_status_type    status
);
   import lst_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_VISIT, ST_CHK, ST_MLO, ST_MHI, ST_WSUM,
      ST_RC0, ST_WC0, ST_RC1, ST_WC1, ST_CLRP, ST_DECIDE, ST_RET,
      ST_MRA, ST_MRB, ST_MWP, ST_FINISH
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] k;
      logic [POS_W-1:0]  lo;
      logic [POS_W-1:0]  hi;
   } frame_type;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [POS_W-1:0]  size_ff, size_in;
   logic              func_ff, func_in;
   logic [POS_W-1:0]  a_ff, a_in, b_ff, b_in;
   frame_type         cur_ff, cur_in;
   logic              pass_ff, pass_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   frame_type         stack_ff [STACK_DEPTH];
   logic              push;
   frame_type         top;
   logic [POS_W-1:0]  n_eff, cur_mid, top_mid;
   logic              covered, disjoint;

   assign n_eff    = (size_ff > POS_W'(LEAVES)) ? POS_W'(LEAVES) : size_ff;
   assign top      = stack_ff[STACK_IDX_W'(sp_ff - SP_W'(1))];
   assign cur_mid  = POS_W'(({1'b0, cur_ff.lo} + {1'b0, cur_ff.hi}) >> 1);
   assign top_mid  = POS_W'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
   assign covered  = (a_ff <= cur_ff.lo) && (cur_ff.hi <= b_ff);
   assign disjoint = (cur_ff.hi < a_ff) || (b_ff < cur_ff.lo);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      size_in      = csr_we ? csr_wdata : size_ff;
      func_in      = func_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      pass_in      = pass_ff;
      sp_in        = sp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      push         = 1'b0;
      cmd.op       = DP_NOP;
      cmd.addr     = cur_ff.k;
      cmd.len      = LEN_W'(cur_ff.hi - cur_ff.lo + POS_W'(1));
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op   = DP_CLEAR;
            cmd.addr = clr_ff;
            clr_in   = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODE_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op  = DP_START;
               func_in = req_func;
               a_in    = req_range_low;
               b_in    = req_range_high;
               cur_in  = '{k: NODE_W'(1), lo: POS_W'(1), hi: n_eff};
               sp_in   = '0;
               pass_in = 1'b0;
               state_in = (n_eff == '0) ? ST_FINISH : ST_VISIT;
            end
         end
         ST_VISIT: begin
            cmd.op   = DP_READ;
            pass_in  = 1'b0;
            state_in = ST_CHK;
         end
         ST_CHK:  state_in = status.p_zero ? ST_DECIDE : ST_MLO;
         ST_MLO: begin
            cmd.op   = DP_MUL_LO;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            cmd.op   = DP_MUL_HI;
            state_in = ST_WSUM;
         end
         ST_WSUM: begin
            cmd.op   = DP_WR_SUM;
            state_in = (cur_ff.lo != cur_ff.hi) ? ST_RC0 : ST_CLRP;
         end
         ST_RC0: begin
            cmd.op   = DP_RD_CHILD;
            cmd.addr = {cur_ff.k[NODE_W-2:0], 1'b0};
            state_in = ST_WC0;
         end
         ST_WC0: begin
            cmd.op   = DP_WR_CHILD;
            cmd.addr = {cur_ff.k[NODE_W-2:0], 1'b0};
            state_in = ST_RC1;
         end
         ST_RC1: begin
            cmd.op   = DP_RD_CHILD;
            cmd.addr = {cur_ff.k[NODE_W-2:0], 1'b1};
            state_in = ST_WC1;
         end
         ST_WC1: begin
            cmd.op   = DP_WR_CHILD;
            cmd.addr = {cur_ff.k[NODE_W-2:0], 1'b1};
            state_in = ST_CLRP;
         end
         ST_CLRP: begin
            cmd.op   = DP_CLR_PEND;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (pass_ff || disjoint) begin
               state_in = ST_RET;
            end else if (covered) begin
               if (func_ff) begin
                  cmd.op   = DP_ACC;
                  state_in = ST_RET;
               end else begin
                  // whole node inside the range: settle again with the add value
                  cmd.op   = DP_LOAD_V;
                  pass_in  = 1'b1;
                  state_in = ST_CHK;
               end
            end else begin
               push     = 1'b1;
               sp_in    = sp_ff + SP_W'(1);
               cur_in   = '{k: {cur_ff.k[NODE_W-2:0], 1'b0}, lo: cur_ff.lo, hi: cur_mid};
               state_in = ST_VISIT;
            end
         end
         ST_RET: begin
            if (sp_ff == '0) begin
               state_in = ST_FINISH;
            end else if (cur_ff.k == {top.k[NODE_W-2:0], 1'b0}) begin
               cur_in   = '{k: {top.k[NODE_W-2:0], 1'b1},
                            lo: top_mid + POS_W'(1), hi: top.hi};
               state_in = ST_VISIT;
            end else begin
               sp_in    = sp_ff - SP_W'(1);
               cur_in   = top;
               state_in = func_ff ? ST_RET : ST_MRA;
            end
         end
         ST_MRA: begin
            cmd.op   = DP_RD_SUM_A;
            cmd.addr = {cur_ff.k[NODE_W-2:0], 1'b0};
            state_in = ST_MRB;
         end
         ST_MRB: begin
            cmd.op   = DP_RD_SUM_B;
            cmd.addr = {cur_ff.k[NODE_W-2:0], 1'b1};
            state_in = ST_MWP;
         end
         ST_MWP: begin
            cmd.op   = DP_WR_PARENT;
            state_in = ST_RET;
         end
         ST_FINISH: begin
            if (!func_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_OUT_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         size_ff      <= SIZE_RESET;
         sp_ff        <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         size_ff      <= size_in;
         sp_ff        <= sp_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      cur_ff  <= cur_in;
      if (push) stack_ff[sp_ff[STACK_IDX_W-1:0]] <= cur_ff;
   end

   `LST_ASSERT(a_stack_bound, sp_ff <= SP_W'(STACK_DEPTH))
   `LST_ASSERT(a_clear_blocks, (state_ff == ST_CLEAR) |-> !req_ready)
   `LST_ASSERT(a_rsp_from_sum, $rose(rsp_valid_ff) |-> $past(func_ff))
   `LST_ASSERT(a_visit_node, (state_ff == ST_VISIT) |-> (cur_ff.k != '0))
endmodule
`default_nettype wire

// File: rtl/lazy_segment_tree_range_add_sum_core.sv
// top level of the lazy segment tree range add and range sum core
// usage:
//   req channel (valid/ready) carries one item: func 0 adds req_add_value to
//   every position in [req_range_low, req_range_high], func 1 asks for the sum.
//   rsp channel (valid/ready) returns one item per sum, none per add.
//   csr_we/csr_wdata write size_in_use (reset 1024, values above 1024 act as 1024).
//   one item is worked at a time; the walk visits each touched tree node and
//   steps through visit, check, decide and return where nothing is pending; a
//   node with a pending add also multiplies it by the node length, writes the
//   node sum, pushes the add to both children (not on a leaf) and clears it;
//   where an add covers the node it is settled again with the add value, and
//   each merge on the way up reads both child sums and writes the parent.
//   a sum over the whole window with nothing pending passes visit, check,
//   decide, return and finish before rsp_valid rises; a narrow range over 1024
//   positions touches about 21 nodes. after reset a clearing pass writes zero to
//   all 4096 nodes, one per cycle; req_ready stays low until the pass ends.
//   a sum result waits in an output register while rsp_ready is low; new items
//   are still accepted, and only the next sum stalls at its end until the
//   register is free.
`default_nettype none
module lazy_segment_tree_range_add_sum_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_func,
   input  wire logic [lst_pkg::POS_W-1:0]  req_range_low,
   input  wire logic [lst_pkg::POS_W-1:0]  req_range_high,
   input  wire logic [lst_pkg::DATA_W-1:0] req_add_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [lst_pkg::DATA_W-1:0]      rsp_range_sum,
   input  wire logic                       csr_we,
   input  wire logic [lst_pkg::POS_W-1:0]  csr_wdata
);
   import lst_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lst_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status)
   );

   lst_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .req_add_value (req_add_value),
      .rsp_range_sum (rsp_range_sum)
   );
endmodule
`default_nettype wire

// File: tb/lst_range_sum_checker.sv
// range sum predictor and result checker for the lazy segment tree core
`default_nettype none
module lst_range_sum_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic                       req_func,
   input  wire logic [lst_pkg::POS_W-1:0]  req_range_low,
   input  wire logic [lst_pkg::POS_W-1:0]  req_range_high,
   input  wire logic [lst_pkg::DATA_W-1:0] req_add_value,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [lst_pkg::DATA_W-1:0] rsp_range_sum,
   input  wire logic                       csr_we,
   input  wire logic [lst_pkg::POS_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              sums_owed
);
   import lst_pkg::*;

   localparam int TREE_NODES = 4 * LEAVES;

   bit [DATA_W-1:0] node_sum [TREE_NODES];
   bit [DATA_W-1:0] node_pend [TREE_NODES];
   bit [POS_W-1:0]  size_reg;
   bit [DATA_W-1:0] sum_queue [$];

   function automatic void push_down(int k, int lo, int hi);
      bit [DATA_W-1:0] p;
      if (k >= TREE_NODES) return;
      p = node_pend[k];
      if (p == 0) return;
      node_sum[k] += DATA_W'(hi - lo + 1) * p;
      if (lo != hi && 2 * k + 1 < TREE_NODES) begin
         node_pend[2 * k] += p;
         node_pend[2 * k + 1] += p;
      end
      node_pend[k] = 0;
   endfunction

   function automatic void tree_add(int k, int lo, int hi, int a, int b,
                                    bit [DATA_W-1:0] v);
      int mid;
      if (k >= TREE_NODES) return;
      push_down(k, lo, hi);
      if (hi < a || b < lo) return;
      if (a <= lo && hi <= b) begin
         node_pend[k] += v;
         push_down(k, lo, hi);
         return;
      end
      mid = (lo + hi) / 2;
      tree_add(2 * k, lo, mid, a, b, v);
      tree_add(2 * k + 1, mid + 1, hi, a, b, v);
      if (2 * k + 1 < TREE_NODES) node_sum[k] = node_sum[2 * k] + node_sum[2 * k + 1];
   endfunction

   function automatic bit [DATA_W-1:0] tree_sum(int k, int lo, int hi, int a, int b);
      int mid;
      if (k >= TREE_NODES) return '0;
      push_down(k, lo, hi);
      if (hi < a || b < lo) return '0;
      if (a <= lo && hi <= b) return node_sum[k];
      mid = (lo + hi) / 2;
      return tree_sum(2 * k, lo, mid, a, b) + tree_sum(2 * k + 1, mid + 1, hi, a, b);
   endfunction

   assign sums_owed = sum_queue.size();

   always @(posedge clock) begin
      int n;
      bit [DATA_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < TREE_NODES; i++) begin
            node_sum[i] = 0;
            node_pend[i] = 0;
         end
         size_reg = SIZE_RESET;
         sum_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sum_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected result item: range_sum %h", rsp_range_sum);
            end else begin
               want = sum_queue.pop_front();
               if (want !== rsp_range_sum) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("range_sum mismatch: expected %h actual %h", want, rsp_range_sum);
               end
            end
         end
         if (req_valid && req_ready) begin
            n = (size_reg > LEAVES) ? LEAVES : int'(size_reg);
            if (req_func) begin
               sum_queue.push_back((n != 0) ?
                  tree_sum(1, 1, n, int'(req_range_low), int'(req_range_high)) : '0);
            end else if (n != 0) begin
               tree_add(1, 1, n, int'(req_range_low), int'(req_range_high), req_add_value);
            end
         end
         if (csr_we) size_reg = csr_wdata;
      end
   end
endmodule
`default_nettype wire

// File: tb/tb_lazy_segment_tree_range_add_sum_core.sv
// stimulus and verdict for the lazy segment tree range add and range sum core
`default_nettype none
module tb_lazy_segment_tree_range_add_sum_core;
   import lst_pkg::*;

   localparam bit FUNC_ADD = 1'b0;
   localparam bit FUNC_SUM = 1'b1;
   localparam int STALL_LIMIT = 30000;
   localparam int SETTLE_CYCLES = 600;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_func = 0;
   logic [POS_W-1:0]  req_range_low = 0;
   logic [POS_W-1:0]  req_range_high = 0;
   logic [DATA_W-1:0] req_add_value = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [DATA_W-1:0] rsp_range_sum;
   logic              csr_we = 0;
   logic [POS_W-1:0]  csr_wdata = 0;
   int                fail_count;
   int                sums_owed;
   bit                idle_on = 1;
   bit                hold_rsp = 0;
   int                quiet_cycles = 0;
   int                cur_size = LEAVES;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   lazy_segment_tree_range_add_sum_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_range_low(req_range_low), .req_range_high(req_range_high),
      .req_add_value(req_add_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_range_sum(rsp_range_sum),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   lst_range_sum_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_range_low(req_range_low), .req_range_high(req_range_high),
      .req_add_value(req_add_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_range_sum(rsp_range_sum),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .sums_owed(sums_owed)
   );

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver with random stall bursts and one long hold-off
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_item(bit f, int lo, int hi, bit [DATA_W-1:0] v);
      int n;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         n = $urandom_range(1, 17);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_range_low <= POS_W'(lo);
      req_range_high <= POS_W'(hi);
      req_add_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock);
      while (sums_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(int s);
      drain_results();
      csr_we <= 1;
      csr_wdata <= POS_W'(s);
      @(posedge clock);
      csr_we <= 0;
      cur_size = (s > LEAVES) ? LEAVES : s;
   endtask

   function automatic int pick_pos();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom_range(0, 2047);
      if (r == 1) return (cur_size == 0) ? 0 : (($urandom_range(0, 1)) ? 1 : cur_size);
      return $urandom_range(0, cur_size + 1);
   endfunction

   function automatic bit [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return {{32{1'b1}}, $urandom};
         default: return DATA_W'($urandom_range(0, 1000)) - DATA_W'(500);
      endcase
   endfunction

   task automatic random_items(int count);
      int a;
      int b;
      for (int i = 0; i < count; i++) begin
         a = pick_pos();
         b = ($urandom_range(0, 5) == 0) ? pick_pos() : a + $urandom_range(0, 40);
         send_item(1'($urandom_range(0, 1)), a, b, pick_value());
      end
   endtask

   initial begin
      int sizes [8] = '{1, 2, 2047, 0, 37, 1000, 7, 1024};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      write_size(LEAVES);

      // directed: extremes, empty and out-of-window ranges
      send_item(FUNC_ADD, 1, 1, {1'b1, 63'b0});
      send_item(FUNC_ADD, 1024, 1024, {1'b0, {63{1'b1}}});
      send_item(FUNC_SUM, 1, 1024, '0);
      send_item(FUNC_SUM, 1, 1, '0);
      send_item(FUNC_SUM, 1024, 1024, '0);
      send_item(FUNC_ADD, 1, 1024, {64{1'b1}});
      send_item(FUNC_SUM, 1, 1024, '0);
      send_item(FUNC_ADD, 500, 400, 64'd77);
      send_item(FUNC_SUM, 500, 400, '0);
      send_item(FUNC_ADD, 0, 2047, 64'd3);
      send_item(FUNC_SUM, 0, 2047, '0);
      send_item(FUNC_ADD, 1025, 2047, 64'd9);
      send_item(FUNC_SUM, 1025, 2047, '0);
      send_item(FUNC_SUM, 0, 0, '0);
      send_item(FUNC_ADD, 2047, 0, 64'd5);
      send_item(FUNC_SUM, 1, 512, '0);
      send_item(FUNC_SUM, 513, 1024, '0);
      send_item(FUNC_ADD, 300, 301, 64'h5555_5555_5555_5555);
      send_item(FUNC_ADD, 1366, 681, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(FUNC_SUM, 299, 302, '0);

      random_items(150);
      hold_rsp = 1;
      random_items(60);
      drain_results();
      random_items(100);

      for (int p = 0; p < 8; p++) begin
         write_size(sizes[p]);
         if (p == 7) idle_on = 0;
         random_items(120);
      end

      drain_results();
      if (fail_count == 0 && sums_owed == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

// File: lazy_segment_tree_range_add_sum_core.f
+incdir+rtl
rtl/lst_pkg.sv
rtl/lst_datapath.sv
rtl/lst_ctrl.sv
rtl/lazy_segment_tree_range_add_sum_core.sv
tb/lst_range_sum_checker.sv
tb/tb_lazy_segment_tree_range_add_sum_core.sv
